// ===== rtl/windowed_integral_ratio_detector_top_defines.svh =====
// Assertion macros shared by the windowed integral ratio detector RTL.
`ifndef WINDOWED_INTEGRAL_RATIO_DETECTOR_TOP_DEFINES_SVH
`define WINDOWED_INTEGRAL_RATIO_DETECTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("windowed integral ratio detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("windowed integral ratio detector: next-cycle check failed");

`endif

// ===== rtl/wir_pkg.sv =====
// Package with the shared constants and types of the windowed integral ratio detector.
`default_nettype none

package wir_pkg;

   // Default sizes of the design.
   localparam int DEF_WINDOW_DEPTH = 16;
   localparam int DEF_SAMPLE_BITS  = 10;
   localparam int DEF_TIME_BITS    = 32;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int WL_BITS        = 4;
   localparam int AMP_BITS       = 16;
   localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd256;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLIFICATION = 2'd1;

   // Shared multiply-accumulate unit.
   localparam int MUL_A_BITS = 16;
   localparam int MUL_B_BITS = 32;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS   = PROD_BITS + MUL_B_BITS;

   typedef struct packed {
      logic go;      // accumulate this cycle
      logic clear;   // start from zero instead of the accumulator
      logic hi;      // product weighted by 2^32
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/wir_ifs.sv =====
// Valid/ready channel interfaces for the sample input and the detection result.
`default_nettype none

interface wir_req_if
   import wir_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int TIME_BITS   = DEF_TIME_BITS
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] brightness;
   logic [TIME_BITS-1:0]   sample_time;

   modport source (output valid, output brightness, output sample_time, input ready);
   modport sink (input valid, input brightness, input sample_time, output ready);
endinterface

interface wir_rsp_if;
   logic valid;
   logic ready;
   logic detected;

   modport source (output valid, output detected, input ready);
   modport sink (input valid, input detected, output ready);
endinterface

`default_nettype wire

// ===== rtl/wir_win_mem.sv =====
// Circular window store holding one sample and its timestamp per entry.
`default_nettype none

module wir_win_mem
   import wir_pkg::*;
#(
   parameter int DEPTH = DEF_WINDOW_DEPTH,
   parameter int WIDTH = DEF_SAMPLE_BITS + DEF_TIME_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/wir_mac.sv =====
// Shared multiply-accumulate unit used for the window integral and the threshold product.
`default_nettype none

module wir_mac
   import wir_pkg::*;
(
   input  wire logic                  clock,
   input  wire mac_ctl_type           ctl,
   input  wire logic [MUL_A_BITS-1:0] op_a,
   input  wire logic [MUL_B_BITS-1:0] op_b,
   output      logic [ACC_BITS-1:0]   acc
);

   logic [ACC_BITS-1:0]  acc_ff;
   logic [ACC_BITS-1:0]  acc_in;
   logic [PROD_BITS-1:0] prod;
   logic [ACC_BITS-1:0]  addend;
   logic [ACC_BITS-1:0]  base;

   always_comb begin
      prod = op_a * op_b;
      if (ctl.hi) begin
         addend = {prod, {MUL_B_BITS{1'b0}}};
      end else begin
         addend = {{MUL_B_BITS{1'b0}}, prod};
      end
      base   = ctl.clear ? '0 : acc_ff;
      acc_in = ctl.go ? (base + addend) : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/windowed_integral_ratio_detector_top.sv =====
// Top level of the windowed integral ratio detector: sequencer, window store and shared MAC.
`default_nettype none
`include "windowed_integral_ratio_detector_top_defines.svh"

// Usage
// The req_bus channel carries one brightness sample and its timestamp per beat; the
// rsp_bus channel returns exactly one beat per sample, holding the detected flag.
// Both are valid/ready channels; a beat moves when valid and ready are high together.
// The csr_ port writes window_length (index 0) or amplification (index 1); any such
// write clears the window, the fill position and the running minimum. Writes are only
// to be made while the block is idle.
// Timing: req_bus.ready is high only while the sequencer is idle. When the new sample is
// the only one in the window, the sequencer goes straight to writing the result, with
// the flag clear. Otherwise the single shared multiplier walks the window (p intervals,
// p up to window_length) one entry per cycle; while the window is filling the flag is
// then clear, and once it is full the multiplier forms amplification times the minimum
// in two 16 by 32 bit passes before the final compare. The next sample can be taken
// once the result is written.
// The result sits in its own output register, so a stalled receiver only holds the
// sequencer once a second result is ready to be written over an untaken one.
// Reset is synchronous and active high; it restores the register defaults (window_length
// 0, amplification 1.0 in Q8.8) and empties the window, which is never read unwritten.
module windowed_integral_ratio_detector_top
   import wir_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int TIME_BITS    = DEF_TIME_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   wir_req_if.sink                        req_bus,
   wir_rsp_if.source                      rsp_bus,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int POS_BITS      = $clog2(WINDOW_DEPTH);
   localparam int ENTRY_BITS    = SAMPLE_BITS + TIME_BITS;
   localparam int INTEGRAL_BITS = SAMPLE_BITS + TIME_BITS + 4;
   localparam int MIN_PAD_BITS  = 2 * MUL_B_BITS;

   localparam logic [POS_BITS-1:0] LAST_POS   = POS_BITS'(WINDOW_DEPTH - 1);
   localparam logic [POS_BITS:0]   DEPTH_WIDE = (POS_BITS + 1)'(WINDOW_DEPTH);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_FETCH    = 9'b000000010,
      ST_ACCUM    = 9'b000000100,
      ST_DRAIN    = 9'b000001000,
      ST_MINUP    = 9'b000010000,
      ST_SCALE_LO = 9'b000100000,
      ST_SCALE_HI = 9'b001000000,
      ST_DECIDE   = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   // Control state.
   state_type              state_ff, state_in;
   logic [WL_BITS-1:0]     wl_ff, wl_in;
   logic [AMP_BITS-1:0]    amp_ff, amp_in;
   logic [POS_BITS-1:0]    fill_ff, fill_in;
   logic [POS_BITS-1:0]    base_ff, base_in;
   logic [INTEGRAL_BITS-1:0] min_ff, min_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mac_ctl_type            ctl_ff, ctl_in;

   // Per-item working registers.
   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic                     full_ff, full_in;
   logic [POS_BITS-1:0]      k_ff, k_in;
   logic [POS_BITS-1:0]      phys_ff, phys_in;
   logic [TIME_BITS-1:0]     prev_t_ff, prev_t_in;
   logic [MUL_A_BITS-1:0]    op_a_ff, op_a_in;
   logic [MUL_B_BITS-1:0]    op_b_ff, op_b_in;
   logic [INTEGRAL_BITS-1:0] integral_ff, integral_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_det_ff, rsp_det_in;

   // Combinational helpers.
   logic [POS_BITS-1:0]      len;
   logic [POS_BITS-1:0]      pos;
   logic [POS_BITS:0]        wr_sum;
   logic                     mem_we;
   logic [POS_BITS-1:0]      mem_waddr;
   logic [ENTRY_BITS-1:0]    mem_wdata;
   logic [ENTRY_BITS-1:0]    mem_rdata;
   logic [SAMPLE_BITS-1:0]   rd_sample;
   logic [TIME_BITS-1:0]     rd_time;
   logic [TIME_BITS-1:0]     dt;
   logic [ACC_BITS-1:0]      acc;
   logic [INTEGRAL_BITS-1:0] new_integral;
   logic [INTEGRAL_BITS-1:0] new_min;
   logic [MIN_PAD_BITS-1:0]  new_min_pad;
   logic [MIN_PAD_BITS-1:0]  min_pad;
   logic [ACC_BITS-1:0]      scaled_integral;
   logic                     req_fire;
   logic                     rsp_free;
   logic                     csr_clear;

   function automatic logic [POS_BITS-1:0] next_ptr(input logic [POS_BITS-1:0] p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   wir_win_mem #(
      .DEPTH (WINDOW_DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_win_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (phys_ff),
      .rd_data (mem_rdata)
   );

   wir_mac u_mac (
      .clock (clock),
      .ctl   (ctl_ff),
      .op_a  (op_a_ff),
      .op_b  (op_b_ff),
      .acc   (acc)
   );

   assign req_fire         = req_bus.valid && req_bus.ready;
   assign rsp_free         = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.detected = rsp_det_ff;

   always_comb begin
      // The effective window length is clamped to what the store can hold.
      if (32'(wl_ff) > 32'(WINDOW_DEPTH - 1)) begin
         len = LAST_POS;
      end else begin
         len = POS_BITS'(wl_ff);
      end
      pos = (fill_ff > len) ? len : fill_ff;

      // Physical slot of the new sample: base plus position, wrapped once.
      wr_sum = {1'b0, base_ff} + {1'b0, pos};
      if (wr_sum >= DEPTH_WIDE) begin
         mem_waddr = POS_BITS'(wr_sum - DEPTH_WIDE);
      end else begin
         mem_waddr = wr_sum[POS_BITS-1:0];
      end
      mem_we    = req_fire;
      mem_wdata = {req_bus.brightness, req_bus.sample_time};

      rd_sample = mem_rdata[ENTRY_BITS-1:TIME_BITS];
      rd_time   = mem_rdata[TIME_BITS-1:0];
      dt        = rd_time - prev_t_ff;

      new_integral    = acc[INTEGRAL_BITS-1:0];
      new_min         = (new_integral < min_ff) ? new_integral : min_ff;
      new_min_pad     = MIN_PAD_BITS'(new_min);
      min_pad         = MIN_PAD_BITS'(min_ff);
      scaled_integral = ACC_BITS'({integral_ff, 8'b0});

      state_in     = state_ff;
      wl_in        = wl_ff;
      amp_in       = amp_ff;
      fill_in      = fill_ff;
      base_in      = base_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_det_in   = rsp_det_ff;
      ctl_in       = '0;
      pos_in       = pos_ff;
      full_in      = full_ff;
      k_in         = k_ff;
      phys_in      = phys_ff;
      prev_t_in    = prev_t_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      integral_in  = integral_ff;
      hit_in       = hit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in  = pos;
               full_in = (pos == len);
               k_in    = '0;
               phys_in = base_ff;
               // A full window slides by advancing the circular base.
               if (pos == len) begin
                  base_in = next_ptr(base_ff);
                  fill_in = pos;
               end else begin
                  fill_in = pos + 1'b1;
               end
               if (pos == '0) begin
                  hit_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // Entry 0 is being read; its data arrives in the first accumulate cycle.
            phys_in  = next_ptr(phys_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // Read data holds window entry k; the read of entry k+1 is under way.
            prev_t_in = rd_time;
            if (k_ff != '0) begin
               op_a_in      = MUL_A_BITS'(rd_sample);
               op_b_in      = MUL_B_BITS'(dt);
               ctl_in.go    = 1'b1;
               ctl_in.clear = (k_ff == POS_BITS'(1));
            end
            phys_in = next_ptr(phys_ff);
            k_in    = k_ff + 1'b1;
            if (k_ff == pos_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MINUP;
         end
         ST_MINUP: begin
            integral_in = new_integral;
            min_in      = new_min;
            if (full_ff) begin
               op_a_in      = amp_ff;
               op_b_in      = new_min_pad[MUL_B_BITS-1:0];
               ctl_in.go    = 1'b1;
               ctl_in.clear = 1'b1;
               state_in     = ST_SCALE_LO;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_SCALE_LO: begin
            op_b_in   = min_pad[MIN_PAD_BITS-1:MUL_B_BITS];
            ctl_in.go = 1'b1;
            ctl_in.hi = 1'b1;
            state_in  = ST_SCALE_HI;
         end
         ST_SCALE_HI: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // The accumulator now holds amplification times the minimum.
            hit_in   = (min_ff != '0) && (scaled_integral > acc);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_det_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes; a write to either listed register empties the window.
      csr_clear = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wl_in     = csr_wdata[WL_BITS-1:0];
               csr_clear = 1'b1;
            end
            CSR_AMPLIFICATION: begin
               amp_in    = csr_wdata[AMP_BITS-1:0];
               csr_clear = 1'b1;
            end
            default: begin
               csr_clear = 1'b0;
            end
         endcase
      end
      if (csr_clear) begin
         fill_in = '0;
         base_in = '0;
         min_in  = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= '0;
         amp_ff       <= AMP_RESET;
         fill_ff      <= '0;
         base_ff      <= '0;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         amp_ff       <= amp_in;
         fill_ff      <= fill_in;
         base_ff      <= base_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      full_ff     <= full_in;
      k_ff        <= k_in;
      phys_ff     <= phys_in;
      prev_t_ff   <= prev_t_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      integral_ff <= integral_in;
      hit_ff      <= hit_in;
      rsp_det_ff  <= rsp_det_in;
   end

   // The fill position never runs past the effective window length.
   `WIR_ASSERT_SAME(a_fill_in_window, clock, reset, 1'b1, fill_ff <= len)
   // An accepted sample keeps the sequencer busy in the following cycle.
   `WIR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_bus.ready)
   // Without a register write the running minimum can only fall.
   `WIR_ASSERT_NEXT(a_min_never_rises, clock, reset, !csr_we, min_ff <= $past(min_ff))

endmodule

`default_nettype wire

// ===== sim/windowed_integral_ratio_detector_top_test.sv =====
// Self-checking testbench for the windowed integral ratio detector top level.
`timescale 1ns / 1ps

module windowed_integral_ratio_detector_top_test
   import wir_pkg::*;
();

   localparam int WINDOW_DEPTH  = DEF_WINDOW_DEPTH;
   localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
   localparam int TIME_BITS     = DEF_TIME_BITS;
   // The integral holds up to fifteen products of a sample and a time step.
   localparam int INTEGRAL_BITS = SAMPLE_BITS + TIME_BITS + 4;

   // Index 2 lies beyond the register list, so a write there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd2;

   localparam int ITEM_TARGET  = 1000;
   // Wait after the last owed flag returns, long enough for any extra result beat to show.
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   // One row of the directed table: either a register write or a sample beat.
   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [SAMPLE_BITS-1:0]    brightness;
      logic [TIME_BITS-1:0]      stamp;
      bit                        typed;
      logic                      detected;
   } stim_row_type;

   // A detection flag that the block owes us, tagged with the beat that caused it.
   typedef struct {
      int   beat_no;
      logic detected;
   } owed_flag_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   wir_req_if #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) req_bus ();
   wir_rsp_if rsp_bus ();

   windowed_integral_ratio_detector_top #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Our own copy of the detector: its registers, its window and its running minimum.
   logic [WL_BITS-1:0]       cfg_window_len;
   logic [AMP_BITS-1:0]      cfg_amplification;
   logic [SAMPLE_BITS-1:0]   win_brightness [WINDOW_DEPTH];
   logic [TIME_BITS-1:0]     win_stamp [WINDOW_DEPTH];
   int unsigned              fill_pos;
   logic [INTEGRAL_BITS-1:0] min_integral;

   owed_flag_type owed_flags[$];
   stim_row_type  directed_rows[$];
   int          beats_sent;
   int          random_beats;
   int          error_count;
   int          cycle_count;
   // While calm is set neither side inserts gaps, giving stretches at full rate.
   bit          calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every register write, and reset, empties the window and re-arms the minimum.
   function automatic void clear_window();
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_brightness[i] = '0;
         win_stamp[i]      = '0;
      end
      fill_pos     = 0;
      min_integral = '1;
   endfunction

   function automatic void apply_register_write(logic [CSR_INDEX_BITS-1:0] idx,
                                                logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_WINDOW_LENGTH: begin
            cfg_window_len = data[WL_BITS-1:0];
            clear_window();
         end
         CSR_AMPLIFICATION: begin
            cfg_amplification = data[AMP_BITS-1:0];
            clear_window();
         end
         default: begin
         end
      endcase
   endfunction

   // Enters one sample into the window and works out the detection flag it yields.
   function automatic logic predict_detection(logic [SAMPLE_BITS-1:0] brightness,
                                              logic [TIME_BITS-1:0] stamp);
      int unsigned              pos;
      int unsigned              span;
      logic [TIME_BITS-1:0]     step;
      logic [INTEGRAL_BITS-1:0] integral;
      logic [63:0]              scaled_integral;
      logic [63:0]              scaled_minimum;
      logic                     hit;

      span = (cfg_window_len > WINDOW_DEPTH - 1) ? WINDOW_DEPTH - 1 : cfg_window_len;
      pos  = (fill_pos > span) ? span : fill_pos;
      win_brightness[pos] = brightness;
      win_stamp[pos]      = stamp;
      integral = '0;
      hit      = 1'b0;

      if (pos > 0) begin
         for (int i = 1; i <= pos; i++) begin
            // Time steps wrap, so a timestamp going backwards counts as a long step.
            step     = win_stamp[i] - win_stamp[i-1];
            integral = integral + INTEGRAL_BITS'(win_brightness[i]) * INTEGRAL_BITS'(step);
         end
         if (integral < min_integral)
            min_integral = integral;
      end

      if (pos == span) begin
         for (int i = 1; i <= pos; i++) begin
            win_brightness[i-1] = win_brightness[i];
            win_stamp[i-1]      = win_stamp[i];
         end
         // The Q8.8 ratio test, done as a cross-multiplication without division.
         if (min_integral != 0 && integral != 0) begin
            scaled_integral = 64'(integral) << 8;
            scaled_minimum  = 64'(cfg_amplification) * 64'(min_integral);
            hit             = scaled_integral > scaled_minimum;
         end
         fill_pos = pos;
      end else begin
         fill_pos = pos + 1;
      end
      return hit;
   endfunction

   // Mostly short gaps, now and then a long one, none at all in a calm phase.
   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what);
      $display("detector check: %s", what);
      error_count++;
   endtask

   // A register is only written once the block is idle and every flag has come back.
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] data);
      req_bus.valid <= 1'b0;
      while (owed_flags.size() != 0 || !req_bus.ready)
         @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_register_write(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one sample beat and, once it is taken, records the flag it must produce.
   task automatic send_beat(logic [SAMPLE_BITS-1:0] brightness, logic [TIME_BITS-1:0] stamp,
                            bit typed, logic typed_flag);
      logic          predicted;
      owed_flag_type owed;
      int            gap;

      req_bus.valid       <= 1'b1;
      req_bus.brightness  <= brightness;
      req_bus.sample_time <= stamp;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);

      // The predictor always runs, so that its window stays in step with the block.
      predicted     = predict_detection(brightness, stamp);
      owed.beat_no  = beats_sent;
      owed.detected = typed ? typed_flag : predicted;
      owed_flags.push_back(owed);
      beats_sent++;

      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_write(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      stim_row_type row;
      row       = '{kind: ROW_WRITE, default: '0};
      row.index = idx;
      row.data  = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_beat(logic [SAMPLE_BITS-1:0] brightness,
                                    logic [TIME_BITS-1:0] stamp, bit typed, logic flag);
      stim_row_type row;
      row            = '{kind: ROW_BEAT, default: '0};
      row.brightness = brightness;
      row.stamp      = stamp;
      row.typed      = typed;
      row.detected   = flag;
      directed_rows.push_back(row);
   endfunction

   // The directed table. A flag is typed in only where it is plain at a glance; the
   // rest of the rows are checked against the predictor.
   function automatic void build_directed_table();
      // Straight after reset the window has no intervals, so nothing is ever detected.
      add_beat(10'd1023, 32'hFFFF_FFFF, 1, 1'b0);
      add_beat(10'd0,    32'h0000_0000, 1, 1'b0);
      add_beat(10'd512,  32'h8000_0000, 1, 1'b0);
      // One interval; the upper data bits must be ignored by the length register.
      add_write(CSR_WINDOW_LENGTH, 16'hFFF1);
      // The first sample only half fills the window.
      add_beat(10'd100, 32'd0, 1, 1'b0);
      // The first integral becomes the minimum, and a ratio of exactly 1.0 does not count.
      add_beat(10'd100, 32'd10, 1, 1'b0);
      // Twice the minimum against a threshold of 1.0.
      add_beat(10'd100, 32'd30, 0, 1'b0);
      // A timestamp going backwards wraps into a huge interval.
      add_beat(10'd1023, 32'd5, 0, 1'b0);
      // A dark sample gives a zero integral, and a zero minimum blocks detection from then on.
      add_beat(10'd0,    32'd100, 1, 1'b0);
      add_beat(10'd1023, 32'd200, 1, 1'b0);
      // A write beyond the register list must not re-arm the minimum.
      add_write(CSR_SPARE_INDEX, 16'hFFFF);
      add_beat(10'd7, 32'd201, 1, 1'b0);
      // Threshold of zero: any nonzero integral over a nonzero minimum is a detection.
      add_write(CSR_AMPLIFICATION, 16'h0000);
      add_write(CSR_WINDOW_LENGTH, 16'h0002);
      add_beat(10'd1023, 32'd1000, 0, 1'b0);
      add_beat(10'd1023, 32'd1010, 0, 1'b0);
      add_beat(10'd1023, 32'd1030, 0, 1'b0);
      add_beat(10'd1,    32'd1031, 0, 1'b0);
      add_beat(10'd1023, 32'hFFFF_FFFF, 0, 1'b0);
      // Longest window and highest threshold; the window cannot fill within these beats.
      add_write(CSR_AMPLIFICATION, 16'hFFFF);
      add_write(CSR_WINDOW_LENGTH, 16'h000F);
      for (int i = 0; i < 8; i++)
         add_beat(10'(i * 146), 32'hFFFF_FFF0 + 32'(i * 3), 1, 1'b0);
   endfunction

   // Writes the registers for one random phase; the extremes turn up regularly.
   task automatic configure_phase();
      logic [CSR_DATA_BITS-1:0] length_word;
      logic [CSR_DATA_BITS-1:0] amp_word;
      int                       roll;

      roll = $urandom_range(0, 19);
      if (roll < 4)
         length_word = 16'd15;
      else if (roll < 6)
         length_word = 16'd0;
      else if (roll < 9)
         length_word = 16'd1;
      else
         length_word = 16'($urandom_range(2, 14));
      // Junk in the unused upper bits of the length word.
      length_word[CSR_DATA_BITS-1:WL_BITS] = 12'($urandom);

      case ($urandom_range(0, 9))
         0:       amp_word = 16'h0000;
         1:       amp_word = 16'hFFFF;
         2:       amp_word = AMP_RESET;
         3, 4:    amp_word = 16'($urandom);
         default: amp_word = 16'($urandom_range(200, 700));
      endcase

      if ($urandom_range(0, 7) == 0)
         write_register(CSR_SPARE_INDEX, 16'($urandom));
      case ($urandom_range(0, 3))
         0:       write_register(CSR_WINDOW_LENGTH, length_word);
         1:       write_register(CSR_AMPLIFICATION, amp_word);
         default: begin
            write_register(CSR_AMPLIFICATION, amp_word);
            write_register(CSR_WINDOW_LENGTH, length_word);
         end
      endcase
   endtask

   // A run of samples with mostly steady time steps and now and then a jump anywhere.
   task automatic random_phase();
      logic [TIME_BITS-1:0]   stamp;
      logic [SAMPLE_BITS-1:0] brightness;
      int                     beats;
      int                     roll;

      calm  = ($urandom_range(0, 3) == 0);
      beats = $urandom_range(20, 120);
      stamp = $urandom;
      for (int n = 0; n < beats; n++) begin
         roll = $urandom_range(0, 9);
         if (roll == 0)
            brightness = '0;
         else if (roll == 1)
            brightness = '1;
         else
            brightness = SAMPLE_BITS'($urandom);

         roll = $urandom_range(0, 99);
         if (roll < 85)
            stamp = stamp + TIME_BITS'($urandom_range(0, 3000));
         else if (roll < 95)
            stamp = $urandom;
         else
            stamp = stamp + 1;

         send_beat(brightness, stamp, 0, 1'b0);
         random_beats++;
      end
      calm = 1'b0;
   endtask

   // Stimulus: reset, the directed table, then random phases until enough beats are in.
   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.brightness  = '0;
      req_bus.sample_time = '0;
      beats_sent          = 0;
      random_beats        = 0;
      error_count         = 0;
      calm                = 1'b0;

      cfg_window_len    = '0;
      cfg_amplification = AMP_RESET;
      clear_window();
      build_directed_table();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE)
            write_register(directed_rows[r].index, directed_rows[r].data);
         else
            send_beat(directed_rows[r].brightness, directed_rows[r].stamp,
                      directed_rows[r].typed, directed_rows[r].detected);
      end

      while (random_beats < ITEM_TARGET) begin
         configure_phase();
         random_phase();
      end

      // Let the last flags come back, then give the block time to show anything extra.
      req_bus.valid <= 1'b0;
      while (owed_flags.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // The receiver takes beats in bursts and stalls between them.
   initial begin : rsp_stalls
      int stall_len;
      rsp_bus.ready <= 1'b1;
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat (calm ? 50 : $urandom_range(1, 16)) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Every beat on the result channel is matched against the oldest flag still owed.
   always @(posedge clock) begin
      owed_flag_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_flags.size() == 0) begin
            report_mismatch($sformatf("result beat with no sample waiting, detected=%0b",
                                      rsp_bus.detected));
         end else begin
            owed = owed_flags.pop_front();
            if (rsp_bus.detected !== owed.detected)
               report_mismatch($sformatf("sample %0d: detected expected %0b, got %0b",
                                         owed.beat_no, owed.detected, rsp_bus.detected));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
